// ----- hw/rtl/bolb_pkg.sv -----
// Shared types and constants for the bounded ordered list buffer.
// No dependencies; used by bolb_ctrl, bolb_datapath and the top level.

package bolb_pkg;

  // Fixed field widths of the item payload.
  localparam int unsigned ActionW   = 3;
  localparam int unsigned PositionW = 5;
  localparam int unsigned WordW     = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountW    = 5;
  localparam int unsigned CapW      = 5;

  // Capacity register value after reset.
  localparam logic [CapW-1:0] CapReset = 5'd10;

  // Register index decoded from the word address.
  localparam logic RegCapacity = 1'b0;

  // Command codes carried by the action field.
  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_INSERT     = 3'd2,
    ACT_REMOVE_AT  = 3'd3,
    ACT_POP_FRONT  = 3'd4,
    ACT_POP_BACK   = 3'd5,
    ACT_CLEAR      = 3'd6,
    ACT_DUMP       = 3'd7
  } act_t;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_BADIDX = 2'd3
  } sts_t;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // accept the item on the input and apply it
    logic dump_step;  // emit the front cell and rotate the row by one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero; // the list holds no elements
    logic dump_last;  // the next dump step emits the final element
    logic slot_free;  // the output register can take a new item
  } stat_t;

endpackage

// ----- hw/rtl/bolb_ctrl.sv -----
// Controller state machine for the bounded ordered list buffer.
// Depends on bolb_pkg for the state, command and status types.

module bolb_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [bolb_pkg::ActionW-1:0]   action,
  input  bolb_pkg::stat_t                stat,
  output logic                           in_ready,
  output bolb_pkg::cmd_t                 cmd
);

  bolb_pkg::state_t state;
  bolb_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bolb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accept items while idle; step the dump while the output slot is free.
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.exec      = 1'b0;
    cmd.dump_step = 1'b0;
    unique case (state)
      bolb_pkg::ST_IDLE: begin
        in_ready = stat.slot_free;
        cmd.exec = in_valid && stat.slot_free;
        if (cmd.exec && action == bolb_pkg::ACT_DUMP && !stat.count_zero) begin
          state_next = bolb_pkg::ST_DUMP;
        end
      end
      bolb_pkg::ST_DUMP: begin
        cmd.dump_step = stat.slot_free;
        if (stat.slot_free && stat.dump_last) begin
          state_next = bolb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bolb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bolb_datapath.sv -----
// Datapath of the bounded ordered list buffer: shifting cell row, element
// count, dump counter and output register. Depends on bolb_pkg.

module bolb_datapath #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bolb_pkg::cmd_t                       cmd,
  output bolb_pkg::stat_t                      stat,
  input  logic [bolb_pkg::CapW-1:0]            capacity,
  input  logic [bolb_pkg::ActionW-1:0]         action,
  input  logic [bolb_pkg::PositionW-1:0]       position,
  input  logic signed [bolb_pkg::WordW-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bolb_pkg::StatusW-1:0]         status,
  output logic [bolb_pkg::CountW-1:0]          count,
  output logic signed [bolb_pkg::WordW-1:0]    element,
  output logic                                 last
);

  // Width of the element count, and a common width for comparisons with
  // the 5-bit position and capacity fields.
  localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > bolb_pkg::CountW) ? CW : bolb_pkg::CountW;
  localparam logic [CMPW-1:0] DepthX = CMPW'(STORE_DEPTH);

  logic signed [bolb_pkg::WordW-1:0] entry      [STORE_DEPTH];
  logic signed [bolb_pkg::WordW-1:0] entry_next [STORE_DEPTH];
  logic [CW-1:0]   elem_cnt;
  logic [CW-1:0]   cnt_next;
  logic [CW-1:0]   remain;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] cnt_next_x;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cap_x;
  logic [CMPW-1:0] limit;
  logic [CMPW-1:0] ins_pos;
  logic [CMPW-1:0] rem_pos;
  logic [CMPW-1:0] top_idx;
  logic            full;
  logic            ins_en;
  logic            rem_en;
  logic            dump_start;
  logic [bolb_pkg::StatusW-1:0] sts;

  assign cnt_x      = CMPW'(elem_cnt);
  assign cnt_next_x = CMPW'(cnt_next);
  assign pos_x      = CMPW'(position);
  assign cap_x      = CMPW'(capacity);
  assign limit      = (cap_x > DepthX) ? DepthX : cap_x;
  assign full       = (cnt_x >= limit);
  assign top_idx    = cnt_x - CMPW'(1);

  // Status toward the controller.
  assign stat.count_zero = (elem_cnt == '0);
  assign stat.dump_last  = (remain == CW'(1));
  assign stat.slot_free  = !out_valid || out_ready;

  // Decode the command: where to open or close a gap, the new count and
  // the result status.
  always_comb begin
    ins_en     = 1'b0;
    rem_en     = 1'b0;
    ins_pos    = '0;
    rem_pos    = '0;
    cnt_next   = elem_cnt;
    sts        = bolb_pkg::STS_OK;
    dump_start = 1'b0;
    case (action)
      bolb_pkg::ACT_PUSH_BACK, bolb_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          sts = bolb_pkg::STS_FULL;
        end else begin
          ins_en   = 1'b1;
          ins_pos  = (action == bolb_pkg::ACT_PUSH_BACK) ? cnt_x : '0;
          cnt_next = elem_cnt + CW'(1);
        end
      end
      bolb_pkg::ACT_INSERT: begin
        if (pos_x > cnt_x) begin
          sts = bolb_pkg::STS_BADIDX;
        end else if (full) begin
          sts = bolb_pkg::STS_FULL;
        end else begin
          ins_en   = 1'b1;
          ins_pos  = pos_x;
          cnt_next = elem_cnt + CW'(1);
        end
      end
      bolb_pkg::ACT_REMOVE_AT: begin
        if (pos_x >= cnt_x) begin
          sts = bolb_pkg::STS_BADIDX;
        end else begin
          rem_en   = 1'b1;
          rem_pos  = pos_x;
          cnt_next = elem_cnt - CW'(1);
        end
      end
      bolb_pkg::ACT_POP_FRONT, bolb_pkg::ACT_POP_BACK: begin
        if (elem_cnt == '0) begin
          sts = bolb_pkg::STS_EMPTY;
        end else begin
          rem_en   = (action == bolb_pkg::ACT_POP_FRONT);
          cnt_next = elem_cnt - CW'(1);
        end
      end
      bolb_pkg::ACT_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        // Dump: an empty list answers at once, otherwise the row streams out.
        if (elem_cnt == '0) begin
          sts = bolb_pkg::STS_EMPTY;
        end else begin
          dump_start = 1'b1;
        end
      end
    endcase
  end

  // Next value of each cell: shift up for an insert, down for a removal,
  // and rotate the occupied part by one for each dump step.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      entry_next[i] = entry[i];
      if (cmd.dump_step) begin
        if (CMPW'(i) == top_idx) begin
          entry_next[i] = entry[0];
        end else begin
          entry_next[i] = entry[(i < STORE_DEPTH - 1) ? i + 1 : i];
        end
      end else if (cmd.exec && ins_en) begin
        if (CMPW'(i) == ins_pos) begin
          entry_next[i] = value;
        end else if (CMPW'(i) > ins_pos) begin
          entry_next[i] = entry[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.exec && rem_en) begin
        if (CMPW'(i) >= rem_pos) begin
          entry_next[i] = entry[(i < STORE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Cell row.
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      entry[i] <= entry_next[i];
    end
  end

  // Element count and remaining dump elements.
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt <= '0;
      remain   <= '0;
    end else begin
      if (cmd.exec) begin
        elem_cnt <= cnt_next;
      end
      if (cmd.exec && dump_start) begin
        remain <= elem_cnt;
      end else if (cmd.dump_step) begin
        remain <= remain - CW'(1);
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.exec && !dump_start) || cmd.dump_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.dump_step) begin
      status  <= bolb_pkg::STS_OK;
      count   <= cnt_x[bolb_pkg::CountW-1:0];
      element <= entry[0];
      last    <= stat.dump_last;
    end else if (cmd.exec && !dump_start) begin
      status  <= sts;
      count   <= cnt_next_x[bolb_pkg::CountW-1:0];
      element <= '0;
      last    <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/bounded_ordered_list_buffer.sv -----
// Top level of the bounded ordered list buffer: capacity register on the
// APB-style port, controller and datapath. Depends on bolb_pkg, bolb_ctrl
// and bolb_datapath.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+--------------------------------
//   input   | in_valid / in_ready    | action, position, value
//   output  | out_valid / out_ready  | status, count, element, last
//   config  | psel, penable, pwrite  | paddr, pwdata, prdata (pready=1)
//
// Every command other than a non-empty dump yields one item from the output
// register, and a new command can be accepted every clock while the output
// is taken. A dump first loads the dump counter, then emits one element per
// cycle while the output is taken, as the cell row rotates through cell 0.
// Input is held off during a dump. Reset clears the count and sets the
// capacity to 10; the cells are not cleared. A stalled output holds its item
// and stops new input and dump steps.

module bounded_ordered_list_buffer #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bolb_pkg::ActionW-1:0]         action,
  input  logic [bolb_pkg::PositionW-1:0]       position,
  input  logic signed [bolb_pkg::WordW-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bolb_pkg::StatusW-1:0]         status,
  output logic [bolb_pkg::CountW-1:0]          count,
  output logic signed [bolb_pkg::WordW-1:0]    element,
  output logic                                 last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [bolb_pkg::CapW-1:0] capacity;
  logic                      cap_sel;
  bolb_pkg::cmd_t            cmd;
  bolb_pkg::stat_t           stat;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[2] == bolb_pkg::RegCapacity);

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bolb_pkg::CapReset;
    end else if (psel && penable && pwrite && cap_sel) begin
      capacity <= pwdata[bolb_pkg::CapW-1:0];
    end
  end

  // Register read-back.
  assign prdata = cap_sel ? 32'(capacity) : 32'd0;

  bolb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bolb_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .capacity  (capacity),
    .action    (action),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count),
    .element   (element),
    .last      (last)
  );

endmodule
